// ===== sv/srld_pkg.sv =====
// Shared constants and controller/datapath link types for the string
// run-length decoder. No dependencies.
`default_nettype none

package srld_pkg;

    localparam int BYTE_W      = 8;
    localparam int NIBBLE_W    = 4;
    localparam int STORE_DEPTH = 15;
    localparam int LOW_BYTES   = 8;
    localparam int HIGH_BYTES  = STORE_DEPTH - LOW_BYTES;
    localparam int LOW_W       = LOW_BYTES * BYTE_W;
    localparam int HIGH_W      = HIGH_BYTES * BYTE_W;

    // controller -> datapath
    typedef struct packed {
        logic load_hdr;   // latch header fields, clear counters
        logic take_lit;   // consume one literal byte
        logic copy_adv;   // one copy request delivered
        logic sel_eos;    // present the end marker on the output
    } t_srld_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hdr_zero;   // incoming byte is zero
        logic len_zero;   // incoming header carries length zero
        logic lit_done;   // this literal completes the chunk
        logic rep_zero;   // latched repeat count is zero
        logic copy_last;  // current copy is the final one
    } t_srld_sts;

endpackage

`default_nettype wire

// ===== sv/srld_if.sv =====
// Valid/ready channel interfaces for the string run-length decoder:
// the compressed byte input and the pattern copy output. Uses srld_pkg.
`default_nettype none

interface srld_in_if import srld_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface srld_out_if import srld_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [LOW_W-1:0]    pattern_low;
    logic [HIGH_W-1:0]   pattern_high;
    logic [NIBBLE_W-1:0] byte_count;
    logic                last_copy;
    logic                end_of_stream;

    modport source (output valid, output pattern_low, output pattern_high,
                    output byte_count, output last_copy, output end_of_stream,
                    input ready);
    modport sink   (input valid, input pattern_low, input pattern_high,
                    input byte_count, input last_copy, input end_of_stream,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/srld_ctrl.sv =====
// Sequencing state machine of the string run-length decoder: header,
// literal gathering, copy emission and end marker. Uses srld_pkg.
`default_nettype none

module srld_ctrl import srld_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    input  wire t_srld_sts i_sts,
    output t_srld_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_HEADER,
        S_LITERAL,
        S_COPY,
        S_END
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, r_out_valid;
    logic   in_fire, out_fire;

    assign in_fire  = i_in_valid && r_in_ready;
    assign out_fire = r_out_valid && i_out_ready;

    // decode commands from the current state and handshakes
    always_comb begin
        o_cmd.load_hdr = in_fire && (r_state == S_HEADER);
        o_cmd.take_lit = in_fire && (r_state == S_LITERAL);
        o_cmd.copy_adv = out_fire && (r_state == S_COPY);
        o_cmd.sel_eos  = (r_state == S_END);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_HEADER: begin
                if (in_fire) begin
                    if (i_sts.hdr_zero) begin
                        n_state = S_END;
                    end else if (!i_sts.len_zero) begin
                        n_state = S_LITERAL;
                    end
                end
            end
            S_LITERAL: begin
                if (in_fire && i_sts.lit_done) begin
                    n_state = i_sts.rep_zero ? S_HEADER : S_COPY;
                end
            end
            S_COPY: begin
                if (out_fire && i_sts.copy_last) begin
                    n_state = S_HEADER;
                end
            end
            S_END: begin
                if (out_fire) begin
                    n_state = S_HEADER;
                end
            end
            default: n_state = S_HEADER;
        endcase
    end

    // hold state and registered handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_HEADER;
            r_in_ready  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= (n_state == S_HEADER) || (n_state == S_LITERAL);
            r_out_valid <= (n_state == S_COPY) || (n_state == S_END);
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== sv/srld_dp.sv =====
// Datapath of the string run-length decoder: header fields, literal
// counters, pattern store and output packing. Uses srld_pkg.
`default_nettype none

module srld_dp import srld_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire t_srld_cmd         i_cmd,
    output t_srld_sts              o_sts,
    output logic [LOW_W-1:0]       o_pattern_low,
    output logic [HIGH_W-1:0]      o_pattern_high,
    output logic [NIBBLE_W-1:0]    o_byte_count,
    output logic                   o_last_copy,
    output logic                   o_end_of_stream
);

    logic [BYTE_W-1:0]   r_store [STORE_DEPTH];
    logic [NIBBLE_W-1:0] r_chunk_len, r_rep_cnt, r_lit_idx, r_valid_len, r_copy_idx;
    logic                r_seen_zero;
    logic [NIBBLE_W-1:0] lit_idx_inc;
    logic [BYTE_W-1:0]   shown [STORE_DEPTH];

    assign lit_idx_inc = r_lit_idx + 1'b1;

    // status toward the controller
    always_comb begin
        o_sts.hdr_zero  = (i_byte == '0);
        o_sts.len_zero  = (i_byte[BYTE_W-1 -: NIBBLE_W] == '0);
        o_sts.lit_done  = (lit_idx_inc == r_chunk_len);
        o_sts.rep_zero  = (r_rep_cnt == '0);
        o_sts.copy_last = (r_copy_idx == (r_rep_cnt - 1'b1));
    end

    // header fields and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_len <= '0;
            r_rep_cnt   <= '0;
            r_lit_idx   <= '0;
            r_valid_len <= '0;
            r_copy_idx  <= '0;
            r_seen_zero <= 1'b0;
        end else if (i_cmd.load_hdr) begin
            r_chunk_len <= i_byte[BYTE_W-1 -: NIBBLE_W];
            r_rep_cnt   <= i_byte[NIBBLE_W-1:0];
            r_lit_idx   <= '0;
            r_valid_len <= '0;
            r_copy_idx  <= '0;
            r_seen_zero <= 1'b0;
        end else if (i_cmd.take_lit) begin
            r_lit_idx <= lit_idx_inc;
            if (!r_seen_zero) begin
                if (i_byte == '0) begin
                    r_seen_zero <= 1'b1;
                end else if (r_lit_idx != NIBBLE_W'(STORE_DEPTH)) begin
                    r_valid_len <= r_valid_len + 1'b1;
                end
            end
        end else if (i_cmd.copy_adv) begin
            r_copy_idx <= r_copy_idx + 1'b1;
        end
    end

    // write nonzero literals ahead of the first zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_lit && !r_seen_zero && (i_byte != '0)
                && (r_lit_idx != NIBBLE_W'(STORE_DEPTH))) begin
            r_store[r_lit_idx] <= i_byte;
        end
    end

    // mask bytes past the valid length; blank everything on the end marker
    always_comb begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            shown[i] = (!i_cmd.sel_eos && (NIBBLE_W'(i) < r_valid_len)) ? r_store[i] : '0;
        end
        for (int i = 0; i < LOW_BYTES; i++) begin
            o_pattern_low[i*BYTE_W +: BYTE_W] = shown[i];
        end
        for (int i = 0; i < HIGH_BYTES; i++) begin
            o_pattern_high[i*BYTE_W +: BYTE_W] = shown[LOW_BYTES + i];
        end
        o_byte_count    = i_cmd.sel_eos ? '0 : r_valid_len;
        o_last_copy     = !i_cmd.sel_eos && o_sts.copy_last;
        o_end_of_stream = i_cmd.sel_eos;
    end

endmodule

`default_nettype wire

// ===== sv/string_run_length_decoder.sv =====
// Top level of the string run-length decoder: joins the controller and the
// datapath to the byte input and pattern output channels. Uses srld_pkg, srld_if.
`default_nettype none

// The decoder takes one compressed byte per request: a header byte (length in
// bits 7:4, repeat count in bits 3:0), then each literal of the chunk. After the
// last literal of a chunk the input stalls while the pattern goes out once per
// repeat, one copy request per cycle as the sink accepts it. A zero header
// yields one end marker, then the decoder waits for a new header. Pattern bytes
// at or above byte_count read as zero. No clearing pass is needed after reset.
module string_run_length_decoder import srld_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    srld_in_if.sink    i_in,
    srld_out_if.source o_out
);

    t_srld_cmd cmd;
    t_srld_sts sts;
    logic      in_ready, out_valid;

    srld_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    srld_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_byte          (i_in.in_byte),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_pattern_low   (o_out.pattern_low),
        .o_pattern_high  (o_out.pattern_high),
        .o_byte_count    (o_out.byte_count),
        .o_last_copy     (o_out.last_copy),
        .o_end_of_stream (o_out.end_of_stream)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for string_run_length_decoder: directed stream
// table followed by random chunk streams, checked against an in-bench decoder.
// Depends on srld_pkg and the srld_in_if / srld_out_if channel interfaces.
`default_nettype none

module testbench import srld_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS        = 480;
    localparam int MAX_GAP      = 18;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 60;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 24;
    localparam int SHOW_MAX     = 10;
    localparam int N_DIRECTED   = 26;

    localparam logic [BYTE_W-1:0] END_HDR  = 8'h00;
    localparam logic [BYTE_W-1:0] CUT_BYTE = 8'h00;

    typedef struct packed {
        logic [LOW_W-1:0]    pattern_low;
        logic [HIGH_W-1:0]   pattern_high;
        logic [NIBBLE_W-1:0] byte_count;
        logic                last_copy;
        logic                end_of_stream;
    } t_copy;

    typedef struct packed {
        logic [BYTE_W-1:0] din;
        logic              has_fixed;
        t_copy             fixed_res;
    } t_stream_row;

    localparam t_copy EOS_MARK   = '{'0, '0, '0, 1'b0, 1'b1};
    localparam t_copy FF_COPY    = '{64'hFF, '0, 4'd1, 1'b1, 1'b0};
    localparam t_copy EMPTY_COPY = '{'0, '0, '0, 1'b1, 1'b0};
    localparam t_copy NO_COPY    = '0;

    // Directed stream; a fixed result is given only where it is obvious
    localparam t_stream_row DIRECTED [N_DIRECTED] = '{
        '{END_HDR, 1'b1, EOS_MARK},     // end marker straight after reset
        '{8'h11,   1'b0, NO_COPY},      // one literal, one copy
        '{8'hFF,   1'b1, FF_COPY},
        '{8'h05,   1'b0, NO_COPY},      // length zero: back to header
        '{8'h10,   1'b0, NO_COPY},      // repeat zero: literal eaten, no copy
        '{8'h01,   1'b0, NO_COPY},
        '{8'h31,   1'b0, NO_COPY},      // zero literal first: empty pattern
        '{8'h00,   1'b0, NO_COPY},
        '{8'h7F,   1'b0, NO_COPY},
        '{8'h80,   1'b1, EMPTY_COPY},
        '{8'hFF,   1'b0, NO_COPY},      // full store, fifteen copies
        '{8'h01,   1'b0, NO_COPY},
        '{8'h02,   1'b0, NO_COPY},
        '{8'h04,   1'b0, NO_COPY},
        '{8'h08,   1'b0, NO_COPY},
        '{8'h10,   1'b0, NO_COPY},
        '{8'h20,   1'b0, NO_COPY},
        '{8'h40,   1'b0, NO_COPY},
        '{8'h80,   1'b0, NO_COPY},
        '{8'hFF,   1'b0, NO_COPY},
        '{8'hFF,   1'b0, NO_COPY},
        '{8'hFF,   1'b0, NO_COPY},
        '{8'hFF,   1'b0, NO_COPY},
        '{8'hFF,   1'b0, NO_COPY},
        '{8'hFF,   1'b0, NO_COPY},
        '{8'hFE,   1'b0, NO_COPY}
    };

    logic i_clk;
    logic i_rst_n;

    srld_in_if  in_ch();
    srld_out_if out_ch();

    string_run_length_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Row currently offered on the byte channel, updated with the bus
    t_stream_row bus_row;

    t_copy copies_due [$];
    t_copy step_copies [$];

    int faults       = 0;
    int bytes_sent   = 0;
    int bytes_taken  = 0;
    int copies_seen  = 0;
    int markers_seen = 0;
    int idle_cycles  = 0;

    // Decoder state mirror
    logic                in_chunk  = 1'b0;
    logic [NIBBLE_W-1:0] chunk_len = '0;
    logic [NIBBLE_W-1:0] copies    = '0;
    logic [NIBBLE_W-1:0] lit_pos   = '0;
    logic [NIBBLE_W-1:0] kept_len  = '0;
    logic                cut       = 1'b0;
    logic [BYTE_W-1:0]   pattern [STORE_DEPTH] = '{default: '0};

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Decode one stream byte into the copies it releases
    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        logic [LOW_W-1:0]  lo;
        logic [HIGH_W-1:0] hi;
        step_copies.delete();
        if (!in_chunk) begin
            if (b == END_HDR) begin
                step_copies.push_back(EOS_MARK);
            end else begin
                chunk_len = b[BYTE_W-1:NIBBLE_W];
                copies    = b[NIBBLE_W-1:0];
                lit_pos   = '0;
                kept_len  = '0;
                cut       = 1'b0;
                in_chunk  = (chunk_len != 0);
            end
        end else begin
            // keep literals up to the first zero byte
            if (!cut) begin
                if (b == CUT_BYTE) begin
                    cut = 1'b1;
                end else if (lit_pos < STORE_DEPTH) begin
                    pattern[lit_pos] = b;
                    kept_len = kept_len + 1'b1;
                end
            end
            lit_pos = lit_pos + 1'b1;
            if (lit_pos == chunk_len) begin
                lo = '0;
                hi = '0;
                for (int i = 0; i < STORE_DEPTH; i++) begin
                    if (i < kept_len) begin
                        if (i < LOW_BYTES)
                            lo[i*BYTE_W +: BYTE_W] = pattern[i];
                        else
                            hi[(i-LOW_BYTES)*BYTE_W +: BYTE_W] = pattern[i];
                    end
                end
                for (int k = 0; k < copies; k++) begin
                    step_copies.push_back('{lo, hi, kept_len, (k == copies - 1), 1'b0});
                end
                in_chunk = 1'b0;
            end
        end
    endfunction

    // Offer one byte after a random gap and hold it until taken
    task automatic send_row(input t_stream_row row, input bit calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= row.din;
        bus_row       <= row;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit calm);
        send_row('{b, 1'b0, NO_COPY}, calm);
    endtask

    // Sample both channels: predict on byte requests, check copy requests
    always @(posedge i_clk) begin
        t_copy got;
        t_copy exp_copy;
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;

            if (in_ch.valid && in_ch.ready) begin
                bytes_taken++;
                decode_byte(in_ch.in_byte);
                if (bus_row.has_fixed)
                    copies_due.push_back(bus_row.fixed_res);
                else
                    foreach (step_copies[i]) copies_due.push_back(step_copies[i]);
            end

            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.pattern_low, out_ch.pattern_high, out_ch.byte_count,
                        out_ch.last_copy, out_ch.end_of_stream};
                if (got.end_of_stream) markers_seen++;
                else copies_seen++;
                if (copies_due.size() == 0) begin
                    faults++;
                    if (faults <= SHOW_MAX)
                        $display("unexpected copy: lo=%h hi=%h count=%0d last=%b eos=%b",
                                 got.pattern_low, got.pattern_high, got.byte_count,
                                 got.last_copy, got.end_of_stream);
                end else begin
                    exp_copy = copies_due.pop_front();
                    if (got.pattern_low   !== exp_copy.pattern_low  ||
                        got.pattern_high  !== exp_copy.pattern_high ||
                        got.byte_count    !== exp_copy.byte_count   ||
                        got.last_copy     !== exp_copy.last_copy    ||
                        got.end_of_stream !== exp_copy.end_of_stream) begin
                        faults++;
                        if (faults <= SHOW_MAX) begin
                            $display("copy mismatch: expected lo=%h hi=%h count=%0d last=%b eos=%b",
                                     exp_copy.pattern_low, exp_copy.pattern_high,
                                     exp_copy.byte_count, exp_copy.last_copy,
                                     exp_copy.end_of_stream);
                            $display("               got      lo=%h hi=%h count=%0d last=%b eos=%b",
                                     got.pattern_low, got.pattern_high, got.byte_count,
                                     got.last_copy, got.end_of_stream);
                        end
                    end
                end
            end
        end
    end

    // Drop ready at random, with one long hold-off to back up the input
    initial begin
        int  stall;
        int  taken;
        bit  held;
        bit  calm;
        held  = 1'b0;
        calm  = 1'b0;
        taken = 0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken % 25 == 0) calm = ($urandom_range(0, 2) == 0);
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (!held && copies_seen >= HOLD_AFTER) begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            taken++;
        end
    end

    // Stop the run when nothing moves for too long
    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("timeout: no request accepted for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Reset, directed table, random chunk streams, drain, verdict
    initial begin
        int  pick;
        int  len;
        int  rep;
        bit  calm;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= '0;
        bus_row       <= '0;
        i_rst_n       <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++) begin
            send_row(DIRECTED[r], (r % 7) < 3);
        end

        calm = 1'b0;
        while (bytes_sent < ITEMS) begin
            if (bytes_sent % 40 == 0) calm = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_byte(END_HDR, calm);
            end else if (pick < 13) begin
                // noise byte, may land in either phase
                send_byte(BYTE_W'($urandom_range(0, 255)), calm);
            end else begin
                pick = $urandom_range(0, 99);
                len  = (pick < 5)  ? 0 :
                       (pick < 15) ? $urandom_range(8, 15) : $urandom_range(1, 6);
                pick = $urandom_range(0, 99);
                rep  = (pick < 10) ? 0 :
                       (pick < 20) ? $urandom_range(8, 15) : $urandom_range(1, 4);
                send_byte({len[NIBBLE_W-1:0], rep[NIBBLE_W-1:0]}, calm);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_byte(CUT_BYTE, calm);
                    else
                        send_byte(BYTE_W'($urandom_range(1, 255)), calm);
                end
            end
        end
        in_ch.valid <= 1'b0;

        // let the monitor log the last byte, wait out the copies, then watch for strays
        @(posedge i_clk);
        while (copies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (copies_due.size() != 0) begin
            faults++;
            $display("%0d expected copies never arrived", copies_due.size());
        end

        $display("Decoded %0d stream bytes (%0d from the directed table) into %0d copies",
                 bytes_taken, N_DIRECTED, copies_seen);
        $display("and %0d end markers, with one %0d-cycle output hold-off; %0d mismatches",
                 markers_seen, HOLD_CYCLES, faults);
        if (faults == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/srld_pkg.sv
sv/srld_if.sv
sv/srld_ctrl.sv
sv/srld_dp.sv
sv/string_run_length_decoder.sv
sim/testbench.sv
